### design/pisa_pkg.sv
// Shared types, constants and saturation helpers for the PID controller.
`timescale 1ns / 1ps
package pisa_pkg;

  localparam int unsigned FlowW    = 13;
  localparam int unsigned VoltW    = 32;
  localparam int unsigned GainW    = 31;
  localparam int unsigned IntegW   = 48;
  localparam int unsigned ProdW    = GainW + VoltW;
  localparam int unsigned FracW    = 24;
  localparam int unsigned TermW    = ProdW - FracW;
  localparam int unsigned IvalW    = 56;
  localparam int unsigned AccW     = 58;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned InDataW  = 48;

  localparam logic [GainW-1:0] GainPRst    = 31'd1677722;
  localparam logic [GainW-1:0] GainIRst    = 31'd2516582;
  localparam logic [GainW-1:0] GainDRst    = 31'd3355443;
  localparam logic [VoltW-1:0] UpperRst    = 32'd167772160;
  localparam logic [VoltW-1:0] LowerRst    = 32'd0;
  localparam logic [GainW-1:0] SlopeRst    = 31'd6711;
  localparam logic [VoltW-1:0] OffsetRst   = 32'd17918067;
  localparam logic [GainW-1:0] SepLimitRst = 31'd50331648;

  typedef enum logic [CfgAddrW-1:0] {
    REG_GAIN_P,
    REG_GAIN_I,
    REG_GAIN_D,
    REG_UPPER_LIMIT,
    REG_LOWER_LIMIT,
    REG_FLOW_SLOPE,
    REG_FLOW_OFFSET,
    REG_SEP_LIMIT
  } reg_idx_e;

  typedef struct packed {
    logic        [GainW-1:0] gain_p;
    logic        [GainW-1:0] gain_i;
    logic        [GainW-1:0] gain_d;
    logic signed [VoltW-1:0] upper_limit;
    logic signed [VoltW-1:0] lower_limit;
    logic        [GainW-1:0] flow_slope;
    logic signed [VoltW-1:0] flow_offset;
    logic        [GainW-1:0] separation_limit;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETP_MUL,
    ST_SETP_ADD,
    ST_ERR,
    ST_MUL_P,
    ST_MUL_D,
    ST_MUL_IL,
    ST_MUL_IH,
    ST_SUM_I,
    ST_ADD_I,
    ST_RESULT
  } state_e;

  // Datapath command, one per cycle
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SETP_MUL,
    OP_SETP_ADD,
    OP_ERR,
    OP_MUL_P,
    OP_MUL_D,
    OP_MUL_IL,
    OP_MUL_IH,
    OP_SUM_I,
    OP_ADD_I,
    OP_RESULT
  } op_e;

  // Two's complement bits in, saturated 32-bit value out
  function automatic logic [VoltW-1:0] sat32(input logic [63:0] v);
    if (&v[63:VoltW-1] || ~|v[63:VoltW-1]) begin
      return v[VoltW-1:0];
    end
    return v[63] ? {1'b1, {(VoltW-1){1'b0}}} : {1'b0, {(VoltW-1){1'b1}}};
  endfunction

  function automatic logic [IntegW-1:0] sat48(input logic [63:0] v);
    if (&v[63:IntegW-1] || ~|v[63:IntegW-1]) begin
      return v[IntegW-1:0];
    end
    return v[63] ? {1'b1, {(IntegW-1){1'b0}}} : {1'b0, {(IntegW-1){1'b1}}};
  endfunction

endpackage

### design/pisa_regs.sv
// Configuration register file with write-only access.
`timescale 1ns / 1ps
module pisa_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pisa_pkg::CfgAddrW-1:0]   cfg_addr_i,
  input  logic [pisa_pkg::VoltW-1:0]      cfg_wdata_i,
  output pisa_pkg::cfg_t                  cfg_o
);
  import pisa_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p           <= GainPRst;
      cfg_q.gain_i           <= GainIRst;
      cfg_q.gain_d           <= GainDRst;
      cfg_q.upper_limit      <= UpperRst;
      cfg_q.lower_limit      <= LowerRst;
      cfg_q.flow_slope       <= SlopeRst;
      cfg_q.flow_offset      <= OffsetRst;
      cfg_q.separation_limit <= SepLimitRst;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_addr_i))
        REG_GAIN_P:      cfg_q.gain_p           <= cfg_wdata_i[GainW-1:0];
        REG_GAIN_I:      cfg_q.gain_i           <= cfg_wdata_i[GainW-1:0];
        REG_GAIN_D:      cfg_q.gain_d           <= cfg_wdata_i[GainW-1:0];
        REG_UPPER_LIMIT: cfg_q.upper_limit      <= cfg_wdata_i;
        REG_LOWER_LIMIT: cfg_q.lower_limit      <= cfg_wdata_i;
        REG_FLOW_SLOPE:  cfg_q.flow_slope       <= cfg_wdata_i[GainW-1:0];
        REG_FLOW_OFFSET: cfg_q.flow_offset      <= cfg_wdata_i;
        REG_SEP_LIMIT:   cfg_q.separation_limit <= cfg_wdata_i[GainW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

### design/pisa_ctrl.sv
// Sequencer: handshakes and the per-step command schedule.
`timescale 1ns / 1ps
module pisa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_valid_i,
  output logic          s_ready_o,
  output logic          m_valid_o,
  input  logic          m_ready_i,
  output pisa_pkg::op_e cmd_o
);
  import pisa_pkg::*;

  state_e state_q, state_d;
  logic   m_valid_q, m_valid_d;
  logic   slot_free;

  assign slot_free = !m_valid_q || m_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (s_valid_i) state_d = ST_SETP_MUL;
      ST_SETP_MUL: state_d = ST_SETP_ADD;
      ST_SETP_ADD: state_d = ST_ERR;
      ST_ERR:      state_d = ST_MUL_P;
      ST_MUL_P:    state_d = ST_MUL_D;
      ST_MUL_D:    state_d = ST_MUL_IL;
      ST_MUL_IL:   state_d = ST_MUL_IH;
      ST_MUL_IH:   state_d = ST_SUM_I;
      ST_SUM_I:    state_d = ST_ADD_I;
      ST_ADD_I:    state_d = ST_RESULT;
      ST_RESULT:   if (slot_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o     = OP_NONE;
    s_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) cmd_o = OP_LOAD;
      end
      ST_SETP_MUL: cmd_o = OP_SETP_MUL;
      ST_SETP_ADD: cmd_o = OP_SETP_ADD;
      ST_ERR:      cmd_o = OP_ERR;
      ST_MUL_P:    cmd_o = OP_MUL_P;
      ST_MUL_D:    cmd_o = OP_MUL_D;
      ST_MUL_IL:   cmd_o = OP_MUL_IL;
      ST_MUL_IH:   cmd_o = OP_MUL_IH;
      ST_SUM_I:    cmd_o = OP_SUM_I;
      ST_ADD_I:    cmd_o = OP_ADD_I;
      ST_RESULT:   if (slot_free) cmd_o = OP_RESULT;
      default:     cmd_o = OP_NONE;
    endcase
  end

  // new result may overwrite the slot in the cycle the old one transfers
  always_comb begin
    m_valid_d = m_valid_q;
    if (cmd_o == OP_RESULT) begin
      m_valid_d = 1'b1;
    end else if (m_ready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  assign m_valid_o = m_valid_q;

endmodule

### design/pisa_dp.sv
// Datapath: shared 31x32 multiplier, accumulator, PID state registers.
`timescale 1ns / 1ps
module pisa_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pisa_pkg::cfg_t                cfg_i,
  input  pisa_pkg::op_e                 cmd_i,
  input  logic [pisa_pkg::FlowW-1:0]    flow_i,
  input  logic [pisa_pkg::VoltW-1:0]    meas_i,
  output logic [pisa_pkg::VoltW-1:0]    drive_o,
  output logic                          used_o
);
  import pisa_pkg::*;

  // payload
  logic        [FlowW-1:0]  flow_q;
  logic signed [VoltW-1:0]  meas_q;
  logic        [ProdW-1:0]  prod_q;
  logic signed [VoltW-1:0]  setp_q;
  logic signed [VoltW-1:0]  err_q;
  logic                     above_q, below_q;
  logic                     used_q, take_q;
  logic                     diff_neg_q;
  logic        [VoltW-1:0]  diff_mag_q;
  logic        [AccW-1:0]   acc_q;
  logic        [TermW-1:0]  ipart_q;
  logic        [IvalW-1:0]  ival_q;
  logic        [VoltW-1:0]  drive_q;
  logic                     used_out_q;
  // controller state, cleared at reset
  logic signed [VoltW-1:0]  prev_meas_q;
  logic signed [VoltW-1:0]  prev_err_q;
  logic signed [IntegW-1:0] integ_q;

  logic        [GainW-1:0]  mul_a;
  logic        [VoltW-1:0]  mul_b;
  logic        [VoltW-1:0]  err_mag;
  logic        [IntegW-1:0] integ_mag;
  logic        [VoltW:0]    diff;
  logic        [TermW-1:0]  term;
  logic        [AccW-1:0]   acc_step;
  logic                     take;

  assign err_mag   = err_q[VoltW-1] ? VoltW'(-err_q) : err_q;
  assign integ_mag = integ_q[IntegW-1] ? IntegW'(-integ_q) : integ_q;
  assign diff      = (VoltW+1)'(err_q) - (VoltW+1)'(prev_err_q);
  assign term      = prod_q[ProdW-1:FracW];

  // upper test wins when the limits cross
  always_comb begin
    if (above_q) begin
      take = err_q[VoltW-1];
    end else if (below_q) begin
      take = !err_q[VoltW-1] && (err_q != '0);
    end else begin
      take = 1'b1;
    end
  end

  always_comb begin
    mul_a = cfg_i.gain_p;
    mul_b = err_mag;
    case (cmd_i)
      OP_SETP_MUL: begin
        mul_a = cfg_i.flow_slope;
        mul_b = VoltW'(flow_q);
      end
      OP_MUL_D: begin
        mul_a = cfg_i.gain_d;
        mul_b = diff_mag_q;
      end
      OP_MUL_IL: begin
        mul_a = cfg_i.gain_i;
        mul_b = integ_mag[VoltW-1:0];
      end
      OP_MUL_IH: begin
        mul_a = cfg_i.gain_i;
        mul_b = VoltW'(integ_mag[IntegW-1:VoltW]);
      end
      default: begin
        mul_a = cfg_i.gain_p;
        mul_b = err_mag;
      end
    endcase
  end

  // signed add of the current product term, sign taken per command
  always_comb begin
    acc_step = acc_q;
    case (cmd_i)
      OP_MUL_D:  acc_step = err_q[VoltW-1] ? acc_q - AccW'(term) : acc_q + AccW'(term);
      OP_MUL_IL: acc_step = diff_neg_q ? acc_q - AccW'(term) : acc_q + AccW'(term);
      OP_ADD_I: begin
        if (used_q) begin
          acc_step = integ_q[IntegW-1] ? acc_q - AccW'(ival_q) : acc_q + AccW'(ival_q);
        end
      end
      default: acc_step = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i)
      OP_LOAD: begin
        flow_q <= flow_i;
        meas_q <= meas_i;
      end
      OP_SETP_MUL: prod_q <= mul_a * mul_b;
      OP_SETP_ADD: setp_q <= sat32(64'(prod_q[43:0]) + 64'(cfg_i.flow_offset));
      OP_ERR: begin
        err_q   <= sat32(64'(setp_q) - 64'(prev_meas_q));
        above_q <= prev_meas_q > cfg_i.upper_limit;
        below_q <= prev_meas_q < cfg_i.lower_limit;
      end
      OP_MUL_P: begin
        prod_q     <= mul_a * mul_b;
        used_q     <= err_mag < VoltW'(cfg_i.separation_limit);
        take_q     <= take;
        diff_neg_q <= diff[VoltW];
        diff_mag_q <= diff[VoltW] ? VoltW'(-diff) : diff[VoltW-1:0];
        acc_q      <= '0;
      end
      OP_MUL_D, OP_MUL_IL: begin
        prod_q <= mul_a * mul_b;
        acc_q  <= acc_step;
      end
      OP_MUL_IH: begin
        prod_q  <= mul_a * mul_b;
        ipart_q <= term;
      end
      OP_SUM_I:  ival_q <= IvalW'(ipart_q) + {prod_q[IvalW-9:0], 8'b0};
      OP_ADD_I:  acc_q  <= acc_step;
      OP_RESULT: begin
        drive_q    <= sat32(64'($signed(acc_q)));
        used_out_q <= used_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_meas_q <= '0;
      prev_err_q  <= '0;
      integ_q     <= '0;
    end else begin
      if (cmd_i == OP_MUL_D && used_q && take_q) begin
        integ_q <= sat48(64'(integ_q) + 64'(err_q));
      end
      if (cmd_i == OP_RESULT) begin
        prev_err_q  <= err_q;
        prev_meas_q <= meas_q;
      end
    end
  end

  assign drive_o = drive_q;
  assign used_o  = used_out_q;

endmodule

### design/pid_integral_separation_antiwindup.sv
// Top level: positional PID with integral separation and anti-windup.
`timescale 1ns / 1ps
// One input transfer yields one result transfer. A step turns the flow
// target into a set point (flow_slope * flow + flow_offset), subtracts the
// measurement captured on the previous step, and forms Kp*e + Kd*(e - e')
// plus Ki*integrator while |e| < separation_limit, all in signed Q8.24 and
// saturated. Every product runs through one shared 31x32 multiplier, five
// products per step; the next input is accepted only once the step is done,
// and the input stays stalled longer only while a finished result is still
// waiting on the output. The user writes registers via the cfg port only
// at idle time (the block does not enforce it); they take effect next step.
module pid_integral_separation_antiwindup (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pisa_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [pisa_pkg::VoltW-1:0]    cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [12:0] flow_target, [44:13] measured_voltage, [47:45] zero
  input  logic [pisa_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [31:0] drive
  output logic [pisa_pkg::VoltW-1:0]    m_axis_tdata,
  // [0] integral_used
  output logic [0:0]                    m_axis_tuser
);
  import pisa_pkg::*;

  cfg_t cfg;
  op_e  cmd;
  logic used;

  pisa_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  pisa_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .cmd_o     (cmd)
  );

  pisa_dp u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .cmd_i   (cmd),
    .flow_i  (s_axis_tdata[FlowW-1:0]),
    .meas_i  (s_axis_tdata[FlowW+VoltW-1:FlowW]),
    .drive_o (m_axis_tdata),
    .used_o  (used)
  );

  assign m_axis_tuser = used;

  // one step at a time: input closes right after a transfer
  a_single_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a step is in progress");

  // a result appears only from the result load command
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(cmd == OP_RESULT))
    else $error("output valid without result load");

  // operands are captured only on a real input transfer
  a_load_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd == OP_LOAD |-> s_axis_tvalid && s_axis_tready)
    else $error("operand capture without input transfer");

endmodule
